[sv/vio_pkg.sv]
package vio_pkg;

  localparam int SECT_W   = 48;
  localparam int CNT_W    = 64;
  localparam int NB_W     = 23;  // size_bytes >> 9
  localparam int NUM_BCNT = 8;
  localparam int NUM_DCNT = 5;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SECT_W-1:0] sector_t;
  typedef logic [NB_W-1:0]   nbsect_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DONE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_BARRIER = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // offsets within the read or write half of the begin counters
  localparam logic [2:0] BC_SECT = 3'd0;
  localparam logic [2:0] BC_REQ  = 3'd1;
  localparam logic [2:0] BC_DIST = 3'd2;
  localparam logic [2:0] BC_SEEK = 3'd3;
  localparam logic [2:0] BC_WR_BASE = 3'd4;

  localparam logic [2:0] DC_ERR     = 3'd0;
  localparam logic [2:0] DC_RD_SECT = 3'd1;
  localparam logic [2:0] DC_RD_REQ  = 3'd2;
  localparam logic [2:0] DC_WR_SECT = 3'd3;
  localparam logic [2:0] DC_WR_REQ  = 3'd4;

  typedef struct packed {
    logic [NUM_BCNT-1:0][CNT_W-1:0] bcnt;
    logic [NUM_DCNT-1:0][CNT_W-1:0] dcnt;
    sector_t                        next;
    logic [1:0]                     kind;
  } slot_t;

  localparam slot_t SLOT_CLEAR = '{bcnt: '0, dcnt: '0, next: '0, kind: KIND_NONE};

endpackage

[sv/volume_io_stats_counter.sv]
// Flow: an accepted transaction reads its slot, then passes through the compute and
// write-back states before out_valid_o rises; no new transaction is taken until it is
// back in idle, and write-back waits while the previous result is held by out_stall_i.
// Reset: a clearing pass writes every slot in turn, with in_stall_o
// held high; all counters read zero and every previous kind is "none" afterwards.
module volume_io_stats_counter #(
  parameter int NUM_VOLUMES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [4:0]        volume_i,
  input  logic [1:0]        io_kind_i,
  input  vio_pkg::sector_t  first_sector_i,
  input  logic [31:0]       size_bytes_i,
  input  logic              failed_i,
  input  logic [3:0]        counter_select_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vio_pkg::cnt_t     counter_value_o,
  output logic              sequential_o,
  output vio_pkg::sector_t  seek_distance_o
);
  import vio_pkg::*;

  localparam int VOL_AW = (NUM_VOLUMES > 1) ? $clog2(NUM_VOLUMES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_WRITE} st_e;

  st_e               state_q;
  logic              out_valid_q;
  logic              clr_busy_q;
  logic [VOL_AW-1:0] clr_cnt_q;
  cnt_t              counter_value_q;
  logic              sequential_q;
  sector_t           seek_distance_q;

  logic              in_accept;
  logic              in_vol_ok;
  logic [VOL_AW-1:0] in_idx;

  op_e               op_q;
  logic [VOL_AW-1:0] idx_q;
  logic              vol_ok_q;
  logic [1:0]        kind_q;
  sector_t           sect_q;
  nbsect_t           nb_q;
  logic              failed_q;
  logic [3:0]        sel_q;

  slot_t             slot_mem [NUM_VOLUMES];
  slot_t             rd_q;
  slot_t             slot_d;
  logic              mem_we;
  logic [VOL_AW-1:0] mem_wa;
  slot_t             mem_wd;

  logic              seq_c, seq_q;
  sector_t           dist_c, dist_q;
  cnt_t              val_c, val_q;
  logic [3:0]        dsel;

  logic [2:0]        base, b_sect, b_req, b_dist, b_seek;
  logic              begin_ok;
  logic              go;

  assign in_stall_o = (state_q != ST_IDLE) || clr_busy_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vol_ok  = 32'(volume_i) < NUM_VOLUMES;
  assign in_idx     = VOL_AW'(volume_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= op_e'(operation_i);
      idx_q    <= in_idx;
      vol_ok_q <= in_vol_ok;
      kind_q   <= io_kind_i;
      sect_q   <= first_sector_i;
      nb_q     <= size_bytes_i[31:9];
      failed_q <= failed_i;
      sel_q    <= counter_select_i;
    end
  end

  // slot memory, one row per volume, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (in_accept && in_vol_ok) begin
      rd_q <= slot_mem[in_idx];
    end
  end

  // compute stage
  always_comb begin
    seq_c  = ((sect_q == rd_q.next) && (kind_q == rd_q.kind)) || (rd_q.kind == KIND_NONE);
    dist_c = (sect_q > rd_q.next) ? (sect_q - rd_q.next) : (rd_q.next - sect_q);
    dsel   = sel_q - 4'(NUM_BCNT);
    if (sel_q < 4'(NUM_BCNT)) begin
      val_c = rd_q.bcnt[sel_q[2:0]];
    end else if (sel_q < 4'(NUM_BCNT + NUM_DCNT)) begin
      val_c = rd_q.dcnt[dsel[2:0]];
    end else begin
      val_c = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      seq_q  <= seq_c;
      dist_q <= dist_c;
      val_q  <= val_c;
    end
  end

  // write-back stage
  assign base   = (kind_q == KIND_READ) ? 3'd0 : BC_WR_BASE;
  assign b_sect = base | BC_SECT;
  assign b_req  = base | BC_REQ;
  assign b_dist = base | BC_DIST;
  assign b_seek = base | BC_SEEK;

  always_comb begin
    slot_d = rd_q;
    case (op_q)
      OP_BEGIN: begin
        if (kind_q != KIND_NONE) begin
          slot_d.bcnt[b_sect] = rd_q.bcnt[b_sect] + cnt_t'(nb_q);
          slot_d.bcnt[b_req]  = rd_q.bcnt[b_req] + cnt_t'(1);
          if (!seq_q) begin
            slot_d.bcnt[b_dist] = rd_q.bcnt[b_dist] + cnt_t'(dist_q);
            slot_d.bcnt[b_seek] = rd_q.bcnt[b_seek] + cnt_t'(1);
          end
          slot_d.next = sect_q + sector_t'(nb_q);
          slot_d.kind = kind_q;
        end
      end
      OP_DONE: begin
        if (failed_q) begin
          slot_d.dcnt[DC_ERR] = rd_q.dcnt[DC_ERR] + cnt_t'(1);
        end else if (kind_q == KIND_READ) begin
          slot_d.dcnt[DC_RD_SECT] = rd_q.dcnt[DC_RD_SECT] + cnt_t'(nb_q);
          slot_d.dcnt[DC_RD_REQ]  = rd_q.dcnt[DC_RD_REQ] + cnt_t'(1);
        end else if (kind_q != KIND_NONE) begin
          slot_d.dcnt[DC_WR_SECT] = rd_q.dcnt[DC_WR_SECT] + cnt_t'(nb_q);
          slot_d.dcnt[DC_WR_REQ]  = rd_q.dcnt[DC_WR_REQ] + cnt_t'(1);
        end
      end
      OP_CLEAR: slot_d = SLOT_CLEAR;
      default: ;
    endcase
  end

  assign go       = (state_q == ST_WRITE) && (!out_valid_q || !out_stall_i);
  assign begin_ok = vol_ok_q && (op_q == OP_BEGIN) && (kind_q != KIND_NONE);

  assign mem_we = clr_busy_q || (go && vol_ok_q && (op_q != OP_READ));
  assign mem_wa = clr_busy_q ? clr_cnt_q : idx_q;
  assign mem_wd = clr_busy_q ? SLOT_CLEAR : slot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      out_valid_q     <= 1'b0;
      clr_busy_q      <= 1'b1;
      clr_cnt_q       <= '0;
      counter_value_q <= '0;
      sequential_q    <= 1'b0;
      seek_distance_q <= '0;
    end else begin
      if (clr_busy_q) begin
        if (clr_cnt_q == VOL_AW'(NUM_VOLUMES - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + VOL_AW'(1);
        end
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: state_q <= ST_WRITE;
        ST_WRITE: begin
          if (go) begin
            state_q         <= ST_IDLE;
            counter_value_q <= (vol_ok_q && (op_q == OP_READ)) ? val_q : '0;
            sequential_q    <= begin_ok && seq_q;
            seek_distance_q <= (begin_ok && !seq_q) ? dist_q : '0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign counter_value_o = counter_value_q;
  assign sequential_o    = sequential_q;
  assign seek_distance_o = seek_distance_q;

endmodule

[sv/vio_checker.sv]
module vio_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] counter_value_o,
  input logic        sequential_o,
  input logic [47:0] seek_distance_o
);

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  a_seq_no_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sequential_o && (seek_distance_o != 48'd0)))
    else $error("sequential result carries a seek distance");

  a_begin_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sequential_o || (seek_distance_o != 48'd0))) |->
      (counter_value_o == 64'd0))
    else $error("begin result carries a counter value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(counter_value_o)
      && $stable(sequential_o) && $stable(seek_distance_o)))
    else $error("stalled result changed");

endmodule

bind volume_io_stats_counter vio_checker u_vio_checker (.*);
